@@ design/glr_pkg.sv @@
// Shared constants and types for the grid line rasterizer.
// Used by glr_ctrl, glr_datapath and grid_line_rasterizer_top; no dependencies.
package glr_pkg;

  // Default grid limits, handed to the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Field widths fixed by the interface.
  localparam int COORD_W = 13;
  localparam int CELL_W  = 8;
  localparam int CFG_W   = 9;
  localparam int RC_W    = 8;

  // Operation codes.
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic order;
    logic setup;
    logic walk;
  } glr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic walk_last;
  } glr_status_t;

endpackage

@@ design/grid_line_rasterizer_top.sv @@
// Grid line rasterizer: Bresenham line drawing into a grid of 8-bit cells.
// A draw walks n points, n being the larger of the column and row spans plus one;
// the walk handles one point a cycle into a read-modify-write grid memory with one
// read and one write port. A read is a one-point walk. The result strobe follows the
// drain states and a new request is taken in the strobe cycle. After reset the grid
// is cleared one cell a cycle with busy high; configuration is reset to 256.
module grid_line_rasterizer_top
  import glr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  output logic                      done_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      op_i,
  input  logic signed [COORD_W-1:0] start_col_i,
  input  logic signed [COORD_W-1:0] start_row_i,
  input  logic signed [COORD_W-1:0] end_col_i,
  input  logic signed [COORD_W-1:0] end_row_i,
  input  logic signed [CELL_W-1:0]  increment_i,
  input  logic [RC_W-1:0]           read_col_i,
  input  logic [RC_W-1:0]           read_row_i,
  output logic signed [CELL_W-1:0]  read_value_o,
  output logic [CFG_W-1:0]          cells_written_o
);

  logic [CFG_W-1:0] grid_width_q, grid_height_q;
  glr_cmd_t         cmd;
  glr_status_t      status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= CFG_W'(256);
      grid_height_q <= CFG_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        REG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  glr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  glr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .op_i            (op_i),
    .start_col_i     (start_col_i),
    .start_row_i     (start_row_i),
    .end_col_i       (end_col_i),
    .end_row_i       (end_row_i),
    .increment_i     (increment_i),
    .read_col_i      (read_col_i),
    .read_row_i      (read_row_i),
    .grid_width_i    (grid_width_q),
    .grid_height_i   (grid_height_q),
    .read_value_o    (read_value_o),
    .cells_written_o (cells_written_o)
  );

  // Results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // An accepted request occupies the block on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (start && !busy) |=> (busy && !done_o))
    else $error("block not busy after accepting a request");

  // A result carries either a read value or a write count, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> ((read_value_o == '0) || (cells_written_o == '0)))
    else $error("read value and write count both non-zero");

endmodule

@@ design/glr_ctrl.sv @@
// Sequencing state machine for the grid line rasterizer.
// Depends on glr_pkg for the command and status structs.
module glr_ctrl
  import glr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  output glr_cmd_t    cmd_o,
  input  glr_status_t status_i
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ORDER  = 3'd2;
  localparam logic [2:0] ST_SETUP  = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_DRAIN1 = 3'd5;
  localparam logic [2:0] ST_DRAIN2 = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  // A new request may be taken while the previous result is on the ports.
  assign busy_o = !((state_q == ST_IDLE) || (state_q == ST_DONE));
  assign done_o = (state_q == ST_DONE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ORDER;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ORDER: begin
        cmd_o.order = 1'b1;
        state_d     = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_last) begin
          state_d = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        state_d = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_d = ST_DONE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/glr_datapath.sv @@
// Line walker, address generator and grid memory for the grid line rasterizer.
// Depends on glr_pkg; driven by commands from glr_ctrl.
module glr_datapath
  import glr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  glr_cmd_t                  cmd_i,
  output glr_status_t               status_o,
  input  logic                      op_i,
  input  logic signed [COORD_W-1:0] start_col_i,
  input  logic signed [COORD_W-1:0] start_row_i,
  input  logic signed [COORD_W-1:0] end_col_i,
  input  logic signed [COORD_W-1:0] end_row_i,
  input  logic signed [CELL_W-1:0]  increment_i,
  input  logic [RC_W-1:0]           read_col_i,
  input  logic [RC_W-1:0]           read_row_i,
  input  logic [CFG_W-1:0]          grid_width_i,
  input  logic [CFG_W-1:0]          grid_height_i,
  output logic signed [CELL_W-1:0]  read_value_o,
  output logic [CFG_W-1:0]          cells_written_o
);

  localparam int Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW  = $clog2(Depth);
  localparam int CfgMax = (1 << CFG_W) - 1;
  localparam int ErrW   = COORD_W + 3;
  localparam int IdxW   = 2 * CFG_W + 1;
  localparam logic [CFG_W-1:0] MaxW = (MAX_WIDTH > CfgMax) ? CFG_W'(CfgMax)
                                                           : CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] MaxH = (MAX_HEIGHT > CfgMax) ? CFG_W'(CfgMax)
                                                            : CFG_W'(MAX_HEIGHT);

  // Active grid size, saturated at the built-in limits.
  logic [CFG_W-1:0] act_w, act_h;
  assign act_w = (grid_width_i > MaxW) ? MaxW : grid_width_i;
  assign act_h = (grid_height_i > MaxH) ? MaxH : grid_height_i;

  // Item registers.
  logic                      op_q;
  logic signed [CELL_W-1:0]  inc_q;
  logic                      steep_q;
  logic signed [COORD_W-1:0] a0_q, b0_q, a1_q, b1_q;
  logic signed [COORD_W-1:0] a_q, b_q;
  logic signed [ErrW-1:0]    err_q, e_up_q, e_dn_q;
  logic                      step_neg_q;
  logic [CFG_W-1:0]          count_q;
  logic signed [CELL_W-1:0]  rd_val_q;

  // Read-modify-write pipeline: address, read, write back.
  logic             p1_valid_q, p2_valid_q;
  logic [AddrW-1:0] p1_addr_q, p2_addr_q;
  logic [CELL_W-1:0] rdata_q;
  logic [AddrW-1:0] clr_addr_q;

  // Load: endpoint spans and orientation.
  logic [COORD_W:0] dc, dr, adc, adr;
  logic             steep_ld;
  logic signed [COORD_W-1:0] rc_ext, rr_ext;

  assign dc       = {end_col_i[COORD_W-1], end_col_i} - {start_col_i[COORD_W-1], start_col_i};
  assign dr       = {end_row_i[COORD_W-1], end_row_i} - {start_row_i[COORD_W-1], start_row_i};
  assign adc      = dc[COORD_W] ? (~dc + 1'b1) : dc;
  assign adr      = dr[COORD_W] ? (~dr + 1'b1) : dr;
  assign steep_ld = (adr > adc);
  assign rc_ext   = {{(COORD_W - RC_W){1'b0}}, read_col_i};
  assign rr_ext   = {{(COORD_W - RC_W){1'b0}}, read_row_i};

  // Setup: major and minor spans of the ordered line.
  logic [COORD_W:0] da, db_raw, db;
  assign da     = {a1_q[COORD_W-1], a1_q} - {a0_q[COORD_W-1], a0_q};
  assign db_raw = {b1_q[COORD_W-1], b1_q} - {b0_q[COORD_W-1], b0_q};
  assign db     = db_raw[COORD_W] ? (~db_raw + 1'b1) : db_raw;

  // Walk: bounds check and cell address of the current point.
  logic [CFG_W-1:0]       amax, bmax, row9, col9;
  logic                   inb;
  logic [2*CFG_W-1:0]     prod;
  logic [IdxW-1:0]        idx;
  logic [COORD_W-1:0]     b_step;

  assign amax = steep_q ? act_h : act_w;
  assign bmax = steep_q ? act_w : act_h;
  assign inb  = !a_q[COORD_W-1] && ($unsigned(a_q) < COORD_W'(amax)) &&
                !b_q[COORD_W-1] && ($unsigned(b_q) < COORD_W'(bmax));
  assign row9 = steep_q ? a_q[CFG_W-1:0] : b_q[CFG_W-1:0];
  assign col9 = steep_q ? b_q[CFG_W-1:0] : a_q[CFG_W-1:0];
  assign prod = row9 * act_w;
  assign idx  = IdxW'(prod) + IdxW'(col9);
  assign b_step = step_neg_q ? {COORD_W{1'b1}} : COORD_W'(1);

  assign status_o.walk_last = (a_q == a1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      inc_q    <= increment_i;
      count_q  <= '0;
      rd_val_q <= '0;
      if (op_i == OP_READ) begin
        // A read is handled as a one-point walk with no write-back.
        steep_q <= 1'b0;
        a0_q    <= rc_ext;
        a1_q    <= rc_ext;
        b0_q    <= rr_ext;
        b1_q    <= rr_ext;
      end else if (steep_ld) begin
        steep_q <= 1'b1;
        a0_q    <= start_row_i;
        a1_q    <= end_row_i;
        b0_q    <= start_col_i;
        b1_q    <= end_col_i;
      end else begin
        steep_q <= 1'b0;
        a0_q    <= start_col_i;
        a1_q    <= end_col_i;
        b0_q    <= start_row_i;
        b1_q    <= end_row_i;
      end
    end
    if (cmd_i.order && (a0_q > a1_q)) begin
      a0_q <= a1_q;
      a1_q <= a0_q;
      b0_q <= b1_q;
      b1_q <= b0_q;
    end
    if (cmd_i.setup) begin
      a_q        <= a0_q;
      b_q        <= b0_q;
      step_neg_q <= !(b0_q < b1_q);
      e_up_q     <= $signed(ErrW'({db, 1'b0}));
      e_dn_q     <= $signed(ErrW'({da - db, 1'b0}));
      err_q      <= $signed(ErrW'({db, 1'b0}) - ErrW'(da));
    end
    if (cmd_i.walk) begin
      a_q <= a_q + COORD_W'(1);
      if (err_q > 0) begin
        b_q   <= b_q + b_step;
        err_q <= err_q - e_dn_q;
      end else begin
        err_q <= err_q + e_up_q;
      end
      if (inb) begin
        count_q <= count_q + CFG_W'(1);
      end
    end
    if (p2_valid_q) begin
      rd_val_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      clr_addr_q <= '0;
    end else begin
      p1_valid_q <= cmd_i.walk && inb;
      p2_valid_q <= p1_valid_q;
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_addr_q <= AddrW'(idx);
    p2_addr_q <= p1_addr_q;
  end

  assign status_o.clr_last = (clr_addr_q == AddrW'(Depth - 1));

  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [CELL_W-1:0] wr_data;

  assign wr_en   = cmd_i.clear || (p2_valid_q && (op_q == OP_DRAW));
  assign wr_addr = cmd_i.clear ? clr_addr_q : p2_addr_q;
  assign wr_data = cmd_i.clear ? '0 : (rdata_q + inc_q);

  logic [CELL_W-1:0] grid_cells_q [Depth];

  // Cells of one line are all distinct, so the read of one point never meets
  // the pending write of an earlier one.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      grid_cells_q[wr_addr] <= wr_data;
    end
    rdata_q <= grid_cells_q[p1_addr_q];
  end

  assign read_value_o    = (op_q == OP_READ) ? rd_val_q : '0;
  assign cells_written_o = (op_q == OP_DRAW) ? count_q : '0;

endmodule
